### hdl/psia_pkg.sv
// Shared types, codes and constants of the slot and id allocator.
`default_nettype none

package psia_pkg;

   // Field widths fixed by the transaction formats.
   localparam int KIND_W      = 2;
   localparam int SLOT_IDX_W  = 6;
   localparam int OWNER_W     = 16;
   localparam int ID_W        = 15;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [ID_W-1:0] ID_MAX = 15'h7FFF;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OCCUPY   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_ROOT_RESERVE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PER_USER_LIMIT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] ROOT_RESERVE_RESET   = 7'd4;
   localparam logic [CSR_DATA_W-1:0] PER_USER_LIMIT_RESET = 7'd32;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [ID_W-1:0]    task_id;
      logic [ID_W-1:0]    group_id;
      logic [ID_W-1:0]    session_id;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic used;
   } scan_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_RESULT
   } state_type;

   // Next candidate id: wrap to 1 after the top, so 0 never appears.
   function automatic logic [ID_W-1:0] advance_id(input logic [ID_W-1:0] v);
      logic [ID_W-1:0] r;
      if (v == ID_MAX) begin
         r = ID_W'(1);
      end else begin
         r = v + ID_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/psia_req_if.sv
// Request channel: table writes and allocate transactions.
`default_nettype none

interface psia_req_if;
   import psia_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic [OWNER_W-1:0]    owner_id;
   logic [ID_W-1:0]       task_id;
   logic [ID_W-1:0]       group_id;
   logic [ID_W-1:0]       session_id;

   modport source (
      output valid, kind, slot_index, owner_id, task_id, group_id, session_id,
      input  ready
   );
   modport sink (
      input  valid, kind, slot_index, owner_id, task_id, group_id, session_id,
      output ready
   );
endinterface

`default_nettype wire

### hdl/psia_rsp_if.sv
// Response channel: status, granted slot and granted id.
`default_nettype none

interface psia_rsp_if;
   import psia_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_IDX_W-1:0] granted_slot;
   logic [ID_W-1:0]       granted_id;

   modport source (output valid, status, granted_slot, granted_id, input ready);
   modport sink   (input valid, status, granted_slot, granted_id, output ready);
endinterface

`default_nettype wire

### hdl/psia_slot_table.sv
// Slot table: used flags in flip-flops, slot fields in a memory with separate write and read ports.
`default_nettype none

module psia_slot_table #(
   parameter int SLOT_COUNT = 64,
   parameter int IDXW       = $clog2(SLOT_COUNT)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic                wr_used,
   input  logic [IDXW-1:0]     wr_addr,
   input  psia_pkg::entry_type wr_entry,
   input  logic [IDXW-1:0]     rd_addr,
   output logic                rd_used,
   output psia_pkg::entry_type rd_entry
);
   import psia_pkg::*;

   logic [SLOT_COUNT-1:0] used_ff;
   entry_type             mem [SLOT_COUNT];
   logic                  rd_used_ff;
   entry_type             rd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_en) begin
         used_ff[wr_addr] <= wr_used;
      end
   end

   // Release only drops the used flag; the fields stay as they were.
   always_ff @(posedge clock) begin
      if (wr_en && wr_used) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[rd_addr];
      rd_used_ff  <= used_ff[rd_addr];
   end

   assign rd_used  = rd_used_ff;
   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

### hdl/psia_scan_unit.sv
// Scan unit: one slot per cycle through the compare and count datapath.
`default_nettype none

module psia_scan_unit #(
   parameter int SLOT_COUNT = 64,
   parameter int IDXW       = $clog2(SLOT_COUNT)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  psia_pkg::scan_ctrl_type      ctrl,
   input  psia_pkg::entry_type          entry,
   input  logic [IDXW-1:0]              slot,
   input  logic [psia_pkg::ID_W-1:0]    cand,
   input  logic [psia_pkg::OWNER_W-1:0] owner,
   output logic                         collide,
   output logic [IDXW-1:0]              free_cnt,
   output logic [IDXW-1:0]              mine_cnt,
   output logic [IDXW-1:0]              lowest
);
   import psia_pkg::*;

   logic            collide_ff;
   logic            found_ff;
   logic [IDXW-1:0] free_cnt_ff;
   logic [IDXW-1:0] mine_cnt_ff;
   logic [IDXW-1:0] lowest_ff;
   logic            hit;

   assign hit = (entry.task_id == cand) || (entry.group_id == cand) ||
                (entry.session_id == cand);

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         collide_ff  <= 1'b0;
         found_ff    <= 1'b0;
         free_cnt_ff <= '0;
         mine_cnt_ff <= '0;
         lowest_ff   <= '0;
      end else if (ctrl.valid) begin
         if (ctrl.used) begin
            if (hit) begin
               collide_ff <= 1'b1;
            end
            if (entry.owner == owner) begin
               mine_cnt_ff <= mine_cnt_ff + IDXW'(1);
            end
         end else begin
            free_cnt_ff <= free_cnt_ff + IDXW'(1);
            // Slots arrive in ascending order: keep the first free one.
            if (!found_ff) begin
               found_ff  <= 1'b1;
               lowest_ff <= slot;
            end
         end
      end
   end

   assign collide  = collide_ff;
   assign free_cnt = free_cnt_ff;
   assign mine_cnt = mine_cnt_ff;
   assign lowest   = lowest_ff;

endmodule

`default_nettype wire

### hdl/process_slot_and_id_allocator_core.sv
// Top level: sequencer, id counter, limit registers and response register.
//
//   channel | direction | handshake            | payload
//   req_ch  | in        | valid/ready          | kind, slot_index, owner_id, ids
//   rsp_ch  | out       | valid/ready          | status, granted_slot, granted_id
//   csr_*   | in        | csr_wr_en, no stall  | csr_index, csr_wr_data
//
// Table write or unknown kind: from idle straight to the result state.
// Allocate: each candidate id tried is one pass through ADVANCE, SCAN, DRAIN
// and DECIDE; each pass walks slots 1 to SLOT_COUNT-1 through the one table
// read port. req_ch.ready is high only when the sequencer is idle.
// A waiting response sits in the output register while the next transaction
// is accepted. Reset clears all used flags at once; no clearing pass.
`default_nettype none

module process_slot_and_id_allocator_core #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   psia_req_if.sink                         req_ch,
   psia_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [psia_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psia_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import psia_pkg::*;

   localparam int IDXW = $clog2(SLOT_COUNT);
   localparam int CMPW = (IDXW > CSR_DATA_W) ? IDXW : CSR_DATA_W;
   localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(SLOT_COUNT - 1);

   state_type             state_ff, state_in;
   logic [IDXW-1:0]       issue_idx_ff, issue_idx_in;
   logic                  pipe_valid_ff;
   logic [IDXW-1:0]       pipe_idx_ff;
   logic [OWNER_W-1:0]    owner_ff, owner_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic [CSR_DATA_W-1:0] root_reserve_ff;
   logic [CSR_DATA_W-1:0] per_user_limit_ff;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [SLOT_IDX_W-1:0] res_slot_ff, res_slot_in;
   logic [ID_W-1:0]       res_id_ff, res_id_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_IDX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;

   logic                  wr_en;
   logic                  in_range;
   logic [31:0]           slot_idx_ext;
   logic [IDXW-1:0]       wr_addr;
   entry_type             wr_entry;
   logic                  rd_used;
   entry_type             rd_entry;
   logic                  scan_clear;
   scan_ctrl_type         scan_ctrl;
   logic                  collide;
   logic [IDXW-1:0]       free_cnt;
   logic [IDXW-1:0]       mine_cnt;
   logic [IDXW-1:0]       lowest;
   logic                  refuse;

   assign slot_idx_ext = {{(32 - SLOT_IDX_W){1'b0}}, req_ch.slot_index};
   assign in_range     = slot_idx_ext < 32'(SLOT_COUNT);
   assign wr_addr      = IDXW'(slot_idx_ext);
   assign wr_entry     = '{owner:      req_ch.owner_id,
                           task_id:    req_ch.task_id,
                           group_id:   req_ch.group_id,
                           session_id: req_ch.session_id};

   psia_slot_table #(.SLOT_COUNT(SLOT_COUNT), .IDXW(IDXW)) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_used  (req_ch.kind == KIND_OCCUPY),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_addr  (issue_idx_ff),
      .rd_used  (rd_used),
      .rd_entry (rd_entry)
   );

   assign scan_ctrl = '{clear: scan_clear, valid: pipe_valid_ff, used: rd_used};

   psia_scan_unit #(.SLOT_COUNT(SLOT_COUNT), .IDXW(IDXW)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .entry    (rd_entry),
      .slot     (pipe_idx_ff),
      .cand     (next_id_ff),
      .owner    (owner_ff),
      .collide  (collide),
      .free_cnt (free_cnt),
      .mine_cnt (mine_cnt),
      .lowest   (lowest)
   );

   // Limits apply to non-root owners only.
   assign refuse = (free_cnt == '0) ||
                   ((owner_ff != '0) &&
                    ((CMPW'(free_cnt) <= CMPW'(root_reserve_ff)) ||
                     (CMPW'(mine_cnt) > CMPW'(per_user_limit_ff))));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pipe_valid_ff <= 1'b0;
         next_id_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pipe_valid_ff <= (state_ff == ST_SCAN);
         next_id_ff    <= next_id_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_reserve_ff   <= ROOT_RESERVE_RESET;
         per_user_limit_ff <= PER_USER_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROOT_RESERVE:   root_reserve_ff   <= csr_wr_data;
            REG_PER_USER_LIMIT: per_user_limit_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff  <= issue_idx_in;
      pipe_idx_ff   <= issue_idx_ff;
      owner_ff      <= owner_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
   end

   always_comb begin
      state_in      = state_ff;
      issue_idx_in  = issue_idx_ff;
      owner_in      = owner_ff;
      next_id_in    = next_id_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_id_in     = res_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      req_ch.ready  = 1'b0;
      wr_en         = 1'b0;
      scan_clear    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               owner_in    = req_ch.owner_id;
               res_slot_in = '0;
               res_id_in   = '0;
               if (req_ch.kind == KIND_ALLOCATE) begin
                  state_in = ST_ADVANCE;
               end else if (req_ch.kind == KIND_OCCUPY || req_ch.kind == KIND_RELEASE) begin
                  wr_en         = in_range;
                  res_status_in = STATUS_WRITTEN;
                  state_in      = ST_RESULT;
               end else begin
                  res_status_in = STATUS_REFUSED;
                  state_in      = ST_RESULT;
               end
            end
         end
         ST_ADVANCE: begin
            next_id_in   = advance_id(next_id_ff);
            scan_clear   = 1'b1;
            issue_idx_in = IDXW'(1);
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue_idx_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               issue_idx_in = issue_idx_ff + IDXW'(1);
            end
         end
         ST_DRAIN: begin
            // Let the last read pass through the scan unit.
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (collide) begin
               state_in = ST_ADVANCE;
            end else begin
               res_status_in = refuse ? STATUS_REFUSED : STATUS_GRANTED;
               res_slot_in   = refuse ? '0 : SLOT_IDX_W'(lowest);
               res_id_in     = next_id_ff;
               state_in      = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_id_in     = res_id_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.granted_slot = rsp_slot_ff;
   assign rsp_ch.granted_id   = rsp_id_ff;

endmodule

`default_nettype wire

### hdl/psia_checker.sv
// Port-level checks on the allocator, bound to the top level.
`default_nettype none

module psia_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [psia_pkg::STATUS_W-1:0]     rsp_status,
   input logic [psia_pkg::SLOT_IDX_W-1:0]   rsp_granted_slot,
   input logic [psia_pkg::ID_W-1:0]         rsp_granted_id
);
   import psia_pkg::*;

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_granted_slot) &&
         $stable(rsp_granted_id))
      else $error("response changed while stalled");

   // The sequencer leaves idle once a transaction is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_grant_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_GRANTED |-> rsp_granted_slot != '0)
      else $error("grant of reserved slot");

   a_no_slot_otherwise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_GRANTED |-> rsp_granted_slot == '0)
      else $error("slot reported without a grant");

   a_write_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_WRITTEN |-> rsp_granted_id == '0)
      else $error("id reported for a table write");

endmodule

bind process_slot_and_id_allocator_core psia_checker u_psia_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_granted_slot (rsp_ch.granted_slot),
   .rsp_granted_id   (rsp_ch.granted_id)
);

`default_nettype wire
